/* sv/etmr_pkg.sv */
// ----------------------------------------------------------------------------
// Explored tile map renderer package
// Shared opcode, state and command types used by controller and datapath.
// ----------------------------------------------------------------------------
package etmr_pkg;

  localparam int unsigned OpW       = 3;
  localparam int unsigned ColorW    = 32;
  localparam int unsigned TotalW    = 11;
  localparam int unsigned CellSizeW = 5;
  localparam int unsigned LevelW    = 4;
  localparam int unsigned CoordW    = 5;
  localparam int unsigned PixW      = 10;
  localparam int unsigned PartyW    = 6;

  // Map geometry; the field widths of the stream port are sized for these.
  localparam int unsigned MapSide     = 32;
  localparam int unsigned LevelCount  = 16;
  localparam int unsigned FrameWidth  = 1024;
  localparam int unsigned FrameHeight = 1024;

  localparam logic [CellSizeW-1:0] DefaultCell = 5'd4;
  localparam logic [ColorW-1:0] ResetWall  = 32'hFF80_8080;
  localparam logic [ColorW-1:0] ResetFloor = 32'hFF40_4040;
  localparam logic [ColorW-1:0] ResetParty = 32'hFF00_FF00;
  localparam logic [TotalW-1:0] TotalMax   = 11'h7FF;

  typedef enum logic [OpW-1:0] {
    OP_REVEAL = 3'd0,
    OP_QUERY  = 3'd1,
    OP_COUNT  = 3'd2,
    OP_LOAD   = 3'd3,
    OP_RENDER = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    REG_CELL_SIZE = 3'd0,
    REG_WALL      = 3'd1,
    REG_FLOOR     = 3'd2,
    REG_PARTY     = 3'd3,
    REG_SHOWN     = 3'd4,
    REG_PCOL      = 3'd5,
    REG_PROW      = 3'd6
  } reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REVEAL,
    ST_QUERY,
    ST_COUNT,
    ST_COUNT_END,
    ST_DIV,
    ST_RENDER,
    ST_READ,
    ST_OUT
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;     // take input item
    logic clear_step;  // clear pass: write zero, advance
    logic walk_init;   // start reveal or count walk
    logic walk_step;   // write/read and advance walk
    logic count_acc;   // accumulate read data
    logic div_start;
    logic div_step;
    logic render_rd;   // issue cell read for render
    logic query_rd;
    logic load_q;      // latch result into output register
    logic res_query;
    logic res_count;
    logic res_render;
    logic load_wr;     // terrain write
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic walk_last;
    logic walk_skip;   // level out of range
    logic div_done;
  } sts_t;

endpackage

/* sv/etmr_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module etmr_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/etmr_ctrl.sv */
// ----------------------------------------------------------------------------
// Explored tile map renderer controller
// Sequences clearing, walks, divides and result hand-off.
// ----------------------------------------------------------------------------
module etmr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [2:0]        in_op_i,
  output logic              in_ready_o,
  input  logic              out_busy_i,
  input  etmr_pkg::sts_t    sts_i,
  output etmr_pkg::cmd_t    cmd_o
);

  etmr_pkg::state_e state_q, state_d;
  logic             accept;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    in_ready_o = (state_q == etmr_pkg::ST_IDLE);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      etmr_pkg::ST_CLEAR: begin
        if (sts_i.clear_done) state_d = etmr_pkg::ST_IDLE;
      end
      etmr_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_op_i)
            etmr_pkg::OP_REVEAL: state_d = etmr_pkg::ST_REVEAL;
            etmr_pkg::OP_QUERY:  state_d = etmr_pkg::ST_QUERY;
            etmr_pkg::OP_COUNT:  state_d = etmr_pkg::ST_COUNT;
            etmr_pkg::OP_RENDER: state_d = etmr_pkg::ST_DIV;
            default:             state_d = etmr_pkg::ST_IDLE;
          endcase
        end
      end
      etmr_pkg::ST_REVEAL: begin
        if (sts_i.walk_skip || sts_i.walk_last) state_d = etmr_pkg::ST_IDLE;
      end
      etmr_pkg::ST_QUERY:  state_d = etmr_pkg::ST_READ;
      etmr_pkg::ST_COUNT: begin
        if (sts_i.walk_skip || sts_i.walk_last) state_d = etmr_pkg::ST_COUNT_END;
      end
      etmr_pkg::ST_COUNT_END: state_d = etmr_pkg::ST_OUT;
      etmr_pkg::ST_DIV: begin
        if (sts_i.div_done) state_d = etmr_pkg::ST_RENDER;
      end
      etmr_pkg::ST_RENDER: state_d = etmr_pkg::ST_READ;
      etmr_pkg::ST_READ:   state_d = etmr_pkg::ST_OUT;
      etmr_pkg::ST_OUT: begin
        if (!out_busy_i) state_d = etmr_pkg::ST_IDLE;
      end
      default: state_d = etmr_pkg::ST_IDLE;
    endcase
  end

  // Remember which result is pending so ST_OUT knows what to latch.
  etmr_pkg::op_e kind_q, kind_d;
  always_comb begin
    kind_d = kind_q;
    if (accept) kind_d = etmr_pkg::op_e'(in_op_i);
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.capture = accept;
    cmd_o.load_wr = accept && (in_op_i == etmr_pkg::OP_LOAD);
    unique case (state_q)
      etmr_pkg::ST_CLEAR:  cmd_o.clear_step = 1'b1;
      etmr_pkg::ST_IDLE:   cmd_o.walk_init = accept;
      etmr_pkg::ST_REVEAL: cmd_o.walk_step = 1'b1;
      etmr_pkg::ST_COUNT: begin
        cmd_o.walk_step = 1'b1;
        cmd_o.count_acc = 1'b1;
      end
      etmr_pkg::ST_COUNT_END: cmd_o.count_acc = 1'b1;
      etmr_pkg::ST_QUERY:  cmd_o.query_rd = 1'b1;
      etmr_pkg::ST_DIV:    cmd_o.div_step = 1'b1;
      etmr_pkg::ST_RENDER: cmd_o.render_rd = 1'b1;
      etmr_pkg::ST_OUT: begin
        cmd_o.load_q     = !out_busy_i;
        cmd_o.res_query  = (kind_q == etmr_pkg::OP_QUERY);
        cmd_o.res_count  = (kind_q == etmr_pkg::OP_COUNT);
        cmd_o.res_render = (kind_q == etmr_pkg::OP_RENDER);
      end
      default: ;
    endcase
    cmd_o.div_start = accept && (in_op_i == etmr_pkg::OP_RENDER);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= etmr_pkg::ST_CLEAR;
      kind_q  <= etmr_pkg::OP_REVEAL;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

/* sv/etmr_dp.sv */
// ----------------------------------------------------------------------------
// Explored tile map renderer datapath
// Explored and terrain memories, walk counters, divider and result register.
// ----------------------------------------------------------------------------
module etmr_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  etmr_pkg::cmd_t        cmd_i,
  output etmr_pkg::sts_t        sts_o,
  input  logic [2:0]            op_i,
  input  logic [3:0]            level_i,
  input  logic [4:0]            cell_x_i,
  input  logic [4:0]            cell_y_i,
  input  logic [4:0]            radius_i,
  input  logic                  is_wall_i,
  input  logic [9:0]            pixel_x_i,
  input  logic [9:0]            pixel_y_i,
  input  logic [4:0]            cell_size_i,
  input  logic [31:0]           wall_color_i,
  input  logic [31:0]           floor_color_i,
  input  logic [31:0]           party_color_i,
  input  logic [3:0]            shown_level_i,
  input  logic [5:0]            party_col_i,
  input  logic [5:0]            party_row_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_busy_o,
  output logic [31:0]           pixel_color_o,
  output logic                  drawn_o,
  output logic                  explored_o,
  output logic [10:0]           explored_total_o
);

  localparam int unsigned MapSide     = etmr_pkg::MapSide;
  localparam int unsigned LevelCount  = etmr_pkg::LevelCount;
  localparam int unsigned FrameWidth  = etmr_pkg::FrameWidth;
  localparam int unsigned FrameHeight = etmr_pkg::FrameHeight;
  localparam int unsigned SideW  = $clog2(MapSide);
  localparam int unsigned LvlW   = (LevelCount > 1) ? $clog2(LevelCount) : 1;
  localparam int unsigned ExpDepth = LevelCount * MapSide * MapSide;
  localparam int unsigned ExpAw  = $clog2(ExpDepth);
  localparam int unsigned TerDepth = MapSide * MapSide;
  localparam int unsigned TerAw  = $clog2(TerDepth);
  localparam int unsigned CW     = SideW + 1;   // signed-free coordinate width
  localparam int unsigned QW     = 12;          // pixel / cs quotient width

  // Captured item.
  logic [3:0] lvl_q;
  logic [4:0] cx_q, cy_q;
  logic [9:0] px_q, py_q;

  // Walk bounds and counters.
  logic [CW-1:0] x0_q, x1_q, y1_q, wx_q, wy_q;
  logic          skip_q;
  logic [CW-1:0] x0_d, x1_d, y0_d, y1_d;
  logic [6:0]    lo_x, lo_y, hi_x, hi_y;
  logic          lvl_ok_in;

  // Clear pass.
  logic [ExpAw-1:0] clr_q;
  logic             clr_last;

  always_comb begin
    lo_x = {2'b0, cell_x_i} - {2'b0, radius_i};
    lo_y = {2'b0, cell_y_i} - {2'b0, radius_i};
    hi_x = {2'b0, cell_x_i} + {2'b0, radius_i};
    hi_y = {2'b0, cell_y_i} + {2'b0, radius_i};
    lvl_ok_in = ({28'd0, level_i} < LevelCount);
    x0_d = lo_x[6] ? '0 : CW'(lo_x);
    y0_d = lo_y[6] ? '0 : CW'(lo_y);
    x1_d = ({25'd0, hi_x} > MapSide - 1) ? CW'(MapSide - 1) : CW'(hi_x);
    y1_d = ({25'd0, hi_y} > MapSide - 1) ? CW'(MapSide - 1) : CW'(hi_y);
    if (op_i == etmr_pkg::OP_COUNT) begin
      x0_d = '0;
      y0_d = '0;
      x1_d = CW'(MapSide - 1);
      y1_d = CW'(MapSide - 1);
    end
  end

  logic walk_last;
  assign walk_last = (wx_q == x1_q) && (wy_q == y1_q);
  assign clr_last  = (clr_q == ExpAw'(ExpDepth - 1));

  // Set in the cycle after a query or render read is issued, when its data is out.
  logic rd_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      skip_q    <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      if (cmd_i.clear_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.walk_init) skip_q <= !lvl_ok_in;
      rd_pend_q <= cmd_i.query_rd || cmd_i.render_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      lvl_q <= level_i;
      cx_q  <= cell_x_i;
      cy_q  <= cell_y_i;
      px_q  <= pixel_x_i;
      py_q  <= pixel_y_i;
    end
    if (cmd_i.walk_init) begin
      x0_q <= x0_d;
      x1_q <= x1_d;
      y1_q <= y1_d;
      wx_q <= x0_d;
      wy_q <= y0_d;
    end else if (cmd_i.walk_step) begin
      if (wx_q == x1_q) begin
        wx_q <= x0_q;
        wy_q <= wy_q + 1'b1;
      end else begin
        wx_q <= wx_q + 1'b1;
      end
    end
  end

  assign sts_o.clear_done = clr_last;
  assign sts_o.walk_last  = walk_last;
  assign sts_o.walk_skip  = skip_q;

  // Pixel divide: restoring, one quotient bit per cycle.
  logic [4:0]    cs;
  logic [QW-1:0] qx_q, qy_q;
  logic [4:0]    rx_q, ry_q;
  logic [9:0]    nx_q, ny_q;
  logic [3:0]    dcnt_q;
  logic [5:0]    tx, ty;

  assign cs = (cell_size_i == '0) ? etmr_pkg::DefaultCell : cell_size_i;
  assign tx = {rx_q, nx_q[9]};
  assign ty = {ry_q, ny_q[9]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      nx_q <= pixel_x_i;
      ny_q <= pixel_y_i;
      rx_q <= '0;
      ry_q <= '0;
      qx_q <= '0;
      qy_q <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      nx_q <= {nx_q[8:0], 1'b0};
      ny_q <= {ny_q[8:0], 1'b0};
      dcnt_q <= dcnt_q + 1'b1;
      if (tx >= {1'b0, cs}) begin
        rx_q <= 5'(tx - {1'b0, cs});
        qx_q <= {qx_q[QW-2:0], 1'b1};
      end else begin
        rx_q <= tx[4:0];
        qx_q <= {qx_q[QW-2:0], 1'b0};
      end
      if (ty >= {1'b0, cs}) begin
        ry_q <= 5'(ty - {1'b0, cs});
        qy_q <= {qy_q[QW-2:0], 1'b1};
      end else begin
        ry_q <= ty[4:0];
        qy_q <= {qy_q[QW-2:0], 1'b0};
      end
    end
  end
  assign sts_o.div_done = (dcnt_q == 4'd9) && cmd_i.div_step;

  // Render checks, registered alongside the memory reads.
  logic gx_ok, gy_ok, pix_ok, shown_ok;
  assign gx_ok    = ({20'd0, qx_q} < MapSide);
  assign gy_ok    = ({20'd0, qy_q} < MapSide);
  assign pix_ok   = ({22'd0, px_q} < FrameWidth) && ({22'd0, py_q} < FrameHeight);
  assign shown_ok = ({28'd0, shown_level_i} < LevelCount);

  logic        mark_hit;
  logic [10:0] mx, my;
  logic        party_on;
  always_comb begin
    party_on = !party_col_i[5] && !party_row_i[5] &&
               ({26'd0, party_col_i} < MapSide) && ({26'd0, party_row_i} < MapSide);
    mx = 11'(party_col_i[4:0] * cs) + 11'(cs[4:1]);
    my = 11'(party_row_i[4:0] * cs) + 11'(cs[4:1]);
    mark_hit = party_on &&
               ({1'b0, px_q} + 11'd1 >= mx) && ({1'b0, px_q} <= mx + 11'd1) &&
               ({1'b0, py_q} + 11'd1 >= my) && ({1'b0, py_q} <= my + 11'd1);
  end

  // Memories.
  logic             exp_we, exp_wd, exp_rd;
  logic [ExpAw-1:0] exp_wa, exp_ra, walk_a;
  logic [LvlW-1:0]  lvl_idx, sh_idx;
  logic             ter_we, ter_rd;
  logic [TerAw-1:0] ter_wa, ter_ra;
  logic             op_i_is_reveal_q;

  assign lvl_idx = LvlW'(lvl_q);
  assign sh_idx  = LvlW'(shown_level_i);
  assign walk_a  = ExpAw'({lvl_idx, wy_q[SideW-1:0], wx_q[SideW-1:0]});

  always_comb begin
    exp_we = 1'b0;
    exp_wd = 1'b0;
    exp_wa = walk_a;
    exp_ra = walk_a;
    if (cmd_i.clear_step) begin
      exp_we = 1'b1;
      exp_wa = clr_q;
    end else if (cmd_i.walk_step && op_i_is_reveal_q && !skip_q) begin
      exp_we = 1'b1;
      exp_wd = 1'b1;
    end
    if (cmd_i.query_rd) begin
      exp_ra = ExpAw'({lvl_idx, cy_q[SideW-1:0], cx_q[SideW-1:0]});
    end else if (cmd_i.render_rd) begin
      exp_ra = ExpAw'({sh_idx, qy_q[SideW-1:0], qx_q[SideW-1:0]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) op_i_is_reveal_q <= (op_i == etmr_pkg::OP_REVEAL);
  end

  assign ter_we = cmd_i.load_wr && ({27'd0, cell_x_i} < MapSide) &&
                  ({27'd0, cell_y_i} < MapSide);
  assign ter_wa = TerAw'({cell_y_i[SideW-1:0], cell_x_i[SideW-1:0]});
  assign ter_ra = TerAw'({qy_q[SideW-1:0], qx_q[SideW-1:0]});

  etmr_ram #(.Width(1), .Depth(ExpDepth)) u_exp (
    .clk_i, .we_i(exp_we), .waddr_i(exp_wa), .wdata_i(exp_wd),
    .raddr_i(exp_ra), .rdata_o(exp_rd)
  );
  etmr_ram #(.Width(1), .Depth(TerDepth)) u_ter (
    .clk_i, .we_i(ter_we), .waddr_i(ter_wa), .wdata_i(is_wall_i),
    .raddr_i(ter_ra), .rdata_o(ter_rd)
  );

  // Validity of the read just issued, aligned with the registered data.
  logic rd_ok_q, hit_q, cnt_v_q;
  logic exp_bit_q, ter_bit_q;
  logic [10:0] cnt_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.query_rd) begin
      rd_ok_q <= ({28'd0, lvl_q} < LevelCount) && ({27'd0, cx_q} < MapSide) &&
                 ({27'd0, cy_q} < MapSide);
    end else if (cmd_i.render_rd) begin
      rd_ok_q <= pix_ok && shown_ok && gx_ok && gy_ok;
      hit_q   <= pix_ok && mark_hit;
    end
    // The memory read port output follows its read address, so the bits are held here
    // until the result is loaded.
    if (rd_pend_q) begin
      exp_bit_q <= exp_rd;
      ter_bit_q <= ter_rd;
    end
    if (cmd_i.walk_init) begin
      cnt_q   <= '0;
      cnt_v_q <= 1'b0;
    end else if (cmd_i.count_acc) begin
      cnt_v_q <= cmd_i.walk_step && !skip_q;
      if (cnt_v_q && exp_rd && cnt_q != etmr_pkg::TotalMax) cnt_q <= cnt_q + 1'b1;
    end
  end

  // Output register.
  logic out_v_q;
  logic exp_hit;
  assign exp_hit = rd_ok_q && exp_bit_q;
  assign out_busy_o = out_v_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.load_q) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_q) begin
      pixel_color_o    <= '0;
      drawn_o          <= 1'b0;
      explored_o       <= 1'b0;
      explored_total_o <= '0;
      if (cmd_i.res_query) explored_o <= exp_hit;
      if (cmd_i.res_count) explored_total_o <= cnt_q;
      if (cmd_i.res_render) begin
        drawn_o <= exp_hit;
        if (hit_q) pixel_color_o <= party_color_i;
        else if (exp_hit) pixel_color_o <= ter_bit_q ? wall_color_i : floor_color_i;
      end
    end
  end

  assign out_valid_o = out_v_q;

endmodule

/* sv/explored_tile_map_renderer_top.sv */
// ----------------------------------------------------------------------------
// Explored tile map renderer
// Reveals, queries and counts explored map cells, loads terrain and renders map pixels.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_axis    in   tdata: opcode, level, cell_x, cell_y, radius, is_wall,
//                       pixel_x, pixel_y
// m_axis    out  tdata: pixel_color, drawn, explored, explored_total
// apb       in   seven registers at byte addresses 0 to 24
//
// After reset a clearing pass over all 16384 explored-memory entries runs
// before the first request is taken.
// Render first runs a ten-step divider. Reveal walks the cells in range and count
// walks every cell of a level; query, render, reveal and count all use the one
// explored memory, while load writes only the terrain memory.
// A result waits in the output register while stalled; the next result is
// held in its last state until that register is free.
// ----------------------------------------------------------------------------
module explored_tile_map_renderer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[2:0], level[6:3], cell_x[11:7], cell_y[16:12], radius[21:17],
  // is_wall[22], pixel_x[32:23], pixel_y[42:33]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_color[31:0], drawn[32], explored[33], explored_total[44:34]
  output logic [47:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0]  cell_size_q;
  logic [31:0] wall_q, floor_q, party_q;
  logic [3:0]  shown_q;
  logic [5:0]  pcol_q, prow_q;
  logic        wr;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= etmr_pkg::DefaultCell;
      wall_q      <= etmr_pkg::ResetWall;
      floor_q     <= etmr_pkg::ResetFloor;
      party_q     <= etmr_pkg::ResetParty;
      shown_q     <= '0;
      pcol_q      <= '1;
      prow_q      <= '1;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (ridx)
        etmr_pkg::REG_CELL_SIZE: cell_size_q <= pwdata[4:0];
        etmr_pkg::REG_WALL:      wall_q      <= pwdata;
        etmr_pkg::REG_FLOOR:     floor_q     <= pwdata;
        etmr_pkg::REG_PARTY:     party_q     <= pwdata;
        etmr_pkg::REG_SHOWN:     shown_q     <= pwdata[3:0];
        etmr_pkg::REG_PCOL:      pcol_q      <= pwdata[5:0];
        etmr_pkg::REG_PROW:      prow_q      <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      etmr_pkg::REG_CELL_SIZE: prdata = {27'd0, cell_size_q};
      etmr_pkg::REG_WALL:      prdata = wall_q;
      etmr_pkg::REG_FLOOR:     prdata = floor_q;
      etmr_pkg::REG_PARTY:     prdata = party_q;
      etmr_pkg::REG_SHOWN:     prdata = {28'd0, shown_q};
      etmr_pkg::REG_PCOL:      prdata = {{26{pcol_q[5]}}, pcol_q};
      etmr_pkg::REG_PROW:      prdata = {{26{prow_q[5]}}, prow_q};
      default:                 prdata = '0;
    endcase
  end

  etmr_pkg::cmd_t cmd;
  etmr_pkg::sts_t sts;
  logic           out_busy;
  logic [31:0]    pix_col;
  logic           drawn, expl;
  logic [10:0]    total;

  etmr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_op_i(s_axis_tdata[2:0]),
    .in_ready_o(s_axis_tready), .out_busy_i(out_busy),
    .sts_i(sts), .cmd_o(cmd)
  );

  etmr_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .op_i(s_axis_tdata[2:0]), .level_i(s_axis_tdata[6:3]),
    .cell_x_i(s_axis_tdata[11:7]), .cell_y_i(s_axis_tdata[16:12]),
    .radius_i(s_axis_tdata[21:17]), .is_wall_i(s_axis_tdata[22]),
    .pixel_x_i(s_axis_tdata[32:23]), .pixel_y_i(s_axis_tdata[42:33]),
    .cell_size_i(cell_size_q), .wall_color_i(wall_q), .floor_color_i(floor_q),
    .party_color_i(party_q), .shown_level_i(shown_q),
    .party_col_i(pcol_q), .party_row_i(prow_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_busy_o(out_busy),
    .pixel_color_o(pix_col), .drawn_o(drawn), .explored_o(expl),
    .explored_total_o(total)
  );

  assign m_axis_tdata = {3'd0, total, expl, drawn, pix_col};

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Explored tile map renderer testbench
// Drives reveal, query, count, terrain load and render requests through the
// stream port and compares every answer against an in-bench map model, over
// several register settings written through the APB port.
// ----------------------------------------------------------------------------
module tb;

  localparam int Side     = 32;
  localparam int Levels   = 16;
  localparam int WdLimit  = 200000;
  localparam int Settle   = 1100;

  typedef struct packed {
    logic [etmr_pkg::TotalW-1:0] total;
    logic                        explored;
    logic                        drawn;
    logic [etmr_pkg::ColorW-1:0] color;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  explored_tile_map_renderer_top dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // Map model
  bit               seen_map [Levels][Side*Side];
  bit               wall_map [Side*Side];
  // Cells whose terrain has been queued for loading; renders only reach these.
  bit               loaded_map [Side*Side];
  logic [4:0]       m_cell = etmr_pkg::DefaultCell;
  logic [31:0]      m_wall = etmr_pkg::ResetWall;
  logic [31:0]      m_floor = etmr_pkg::ResetFloor;
  logic [31:0]      m_party = etmr_pkg::ResetParty;
  logic [3:0]       m_shown = '0;
  logic signed [5:0] m_pcol = -6'sd1;
  logic signed [5:0] m_prow = -6'sd1;

  logic [47:0] pending_req [$];
  answer_t     awaited [$];
  int          n_err = 0;
  bit          quiet = 1'b0;
  int          req_gap = 0;
  int          rdy_gap = 0;
  int          wd_cnt = 0;

  function automatic logic [47:0] pack_req(etmr_pkg::op_e op, logic [3:0] lvl,
                                          logic [4:0] cx, logic [4:0] cy,
                                          logic [4:0] r, logic w,
                                          logic [9:0] px, logic [9:0] py);
    return {5'b0, py, px, w, r, cy, cx, lvl, op};
  endfunction

  function automatic bit in_map(int x, int y);
    return x >= 0 && x < Side && y >= 0 && y < Side;
  endfunction

  task automatic apply_request(logic [47:0] d);
    logic [2:0] op;
    int lvl, cx, cy, r, px, py, x0, x1, y0, y1, cs, gx, gy, mx, my, n;
    answer_t a;
    op = d[2:0]; lvl = d[6:3]; cx = d[11:7]; cy = d[16:12]; r = d[21:17];
    px = d[32:23]; py = d[42:33];
    a = '0;
    case (op)
      etmr_pkg::OP_REVEAL: begin
        x0 = (cx - r < 0) ? 0 : cx - r;
        y0 = (cy - r < 0) ? 0 : cy - r;
        x1 = (cx + r > Side - 1) ? Side - 1 : cx + r;
        y1 = (cy + r > Side - 1) ? Side - 1 : cy + r;
        for (int y = y0; y <= y1; y++)
          for (int x = x0; x <= x1; x++) seen_map[lvl][y*Side+x] = 1'b1;
      end
      etmr_pkg::OP_QUERY: begin
        a.explored = seen_map[lvl][cy*Side+cx];
        awaited.push_back(a);
      end
      etmr_pkg::OP_COUNT: begin
        n = 0;
        for (int i = 0; i < Side*Side; i++) n += seen_map[lvl][i];
        a.total = (n > 2047) ? etmr_pkg::TotalMax : n[etmr_pkg::TotalW-1:0];
        awaited.push_back(a);
      end
      etmr_pkg::OP_LOAD: wall_map[cy*Side+cx] = d[22];
      etmr_pkg::OP_RENDER: begin
        cs = (m_cell == 0) ? 4 : int'(m_cell);
        gx = px / cs;
        gy = py / cs;
        if (in_map(gx, gy) && seen_map[m_shown][gy*Side+gx]) begin
          a.color = wall_map[gy*Side+gx] ? m_wall : m_floor;
          a.drawn = 1'b1;
        end
        if (in_map(m_pcol, m_prow)) begin
          mx = int'(m_pcol) * cs + cs / 2;
          my = int'(m_prow) * cs + cs / 2;
          if (px >= mx - 1 && px <= mx + 1 && py >= my - 1 && py <= my + 1)
            a.color = m_party;
        end
        awaited.push_back(a);
      end
      default: ;
    endcase
  endtask

  // Request driver: a request stays presented until it is taken.
  always @(posedge clk_i) begin
    logic        nv;
    logic [47:0] nd;
    if (rst_ni) begin
      nv = s_axis_tvalid;
      nd = s_axis_tdata;
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(s_axis_tdata);
        nv = 1'b0;
      end
      if (!nv) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (pending_req.size() > 0) begin
          if (!quiet && $urandom_range(0, 5) == 0) begin
            req_gap = $urandom_range(0, 3);
          end else begin
            nd = pending_req.pop_front();
            nv = 1'b1;
          end
        end
      end
      s_axis_tvalid <= nv;
      s_axis_tdata  <= nd;
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i) begin
    answer_t got, want;
    logic    nr;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[44:0];
        if (awaited.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          want = awaited.pop_front();
          if (got.color !== want.color || got.drawn !== want.drawn ||
              got.explored !== want.explored || got.total !== want.total) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: colour %h/%h drawn %b/%b explored %b/%b total %0d/%0d",
                       want.color, got.color, want.drawn, got.drawn,
                       want.explored, got.explored, want.total, got.total);
          end
        end
      end
      if (rdy_gap > 0) begin
        rdy_gap--;
        nr = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        rdy_gap = $urandom_range(0, 3);
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
      m_axis_tready <= nr;
    end
  end

  // Watchdog on cycles without any accepted request, result or APB access.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      wd_cnt <= 0;
    end else begin
      wd_cnt <= wd_cnt + 1;
      if (wd_cnt >= WdLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_req.size() > 0 || s_axis_tvalid || awaited.size() > 0)
      @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic reg_write(etmr_pkg::reg_e idx, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      etmr_pkg::REG_CELL_SIZE: m_cell = v[4:0];
      etmr_pkg::REG_WALL:      m_wall = v;
      etmr_pkg::REG_FLOOR:     m_floor = v;
      etmr_pkg::REG_PARTY:     m_party = v;
      etmr_pkg::REG_SHOWN:     m_shown = v[3:0];
      etmr_pkg::REG_PCOL:      m_pcol = v[5:0];
      default:                 m_prow = v[5:0];
    endcase
  endtask

  // Queues a request; a render of a cell whose terrain was never loaded is
  // preceded by a load of that cell.
  task automatic push_item(logic [47:0] d);
    int cs, gx, gy;
    if (d[2:0] == etmr_pkg::OP_RENDER) begin
      cs = (m_cell == 0) ? 4 : int'(m_cell);
      gx = int'(d[32:23]) / cs;
      gy = int'(d[42:33]) / cs;
      if (in_map(gx, gy) && !loaded_map[gy*Side+gx]) begin
        pending_req.push_back(pack_req(etmr_pkg::OP_LOAD, 4'd0, 5'(gx), 5'(gy), 5'd0,
                                       1'($urandom()), 10'd0, 10'd0));
        loaded_map[gy*Side+gx] = 1'b1;
      end
    end else if (d[2:0] == etmr_pkg::OP_LOAD) begin
      loaded_map[int'(d[16:12])*Side + int'(d[11:7])] = 1'b1;
    end
    pending_req.push_back(d);
  endtask

  task automatic push_random(int count);
    logic [47:0] d;
    int k, cs, span;
    etmr_pkg::op_e op;
    for (int i = 0; i < count; i++) begin
      d = 48'({$urandom(), $urandom()});
      d[47:43] = '0;
      k = $urandom_range(0, 99);
      if (k < 25) op = etmr_pkg::OP_REVEAL;
      else if (k < 40) op = etmr_pkg::OP_QUERY;
      else if (k < 46) op = etmr_pkg::OP_COUNT;
      else if (k < 56) op = etmr_pkg::OP_LOAD;
      else op = etmr_pkg::OP_RENDER;
      d[2:0] = op;
      if ($urandom_range(0, 1) == 0) d[6:3] = m_shown;
      if (op == etmr_pkg::OP_REVEAL && $urandom_range(0, 9) != 0)
        d[21:17] = 5'($urandom_range(0, 3));
      if (op == etmr_pkg::OP_RENDER && $urandom_range(0, 4) != 0) begin
        cs = (m_cell == 0) ? 4 : int'(m_cell);
        span = Side * cs + 2;
        if (span > 1023) span = 1023;
        d[32:23] = 10'($urandom_range(0, span));
        d[42:33] = 10'($urandom_range(0, span));
      end
      if ($urandom_range(0, 39) == 0) d[2:0] = 3'($urandom_range(5, 7));
      push_item(d);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests under the reset register values.
    push_item(pack_req(etmr_pkg::OP_REVEAL, 0, 0, 0, 0, 0, 0, 0));
    push_item(pack_req(etmr_pkg::OP_REVEAL, 15, 31, 31, 31, 1, 10'h3FF, 10'h3FF));
    push_item(pack_req(etmr_pkg::OP_REVEAL, 0, 16, 16, 2, 0, 0, 0));
    push_item(pack_req(etmr_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0));
    push_item(pack_req(etmr_pkg::OP_QUERY, 15, 31, 31, 31, 1, 0, 0));
    push_item(pack_req(etmr_pkg::OP_QUERY, 3, 5, 5, 0, 0, 0, 0));
    push_item(pack_req(etmr_pkg::OP_COUNT, 0, 0, 0, 0, 0, 0, 0));
    push_item(pack_req(etmr_pkg::OP_COUNT, 15, 0, 0, 0, 0, 0, 0));
    push_item(pack_req(etmr_pkg::OP_COUNT, 3, 0, 0, 0, 0, 0, 0));
    push_item(pack_req(etmr_pkg::OP_LOAD, 0, 0, 0, 0, 1, 0, 0));
    push_item(pack_req(etmr_pkg::OP_LOAD, 0, 31, 31, 0, 0, 0, 0));
    push_item(pack_req(etmr_pkg::OP_RENDER, 0, 0, 0, 0, 0, 0, 0));
    push_item(pack_req(etmr_pkg::OP_RENDER, 0, 0, 0, 0, 0, 66, 66));
    push_item(pack_req(etmr_pkg::OP_RENDER, 0, 0, 0, 0, 0, 127, 127));
    push_item(pack_req(etmr_pkg::OP_RENDER, 0, 0, 0, 0, 0, 10'h3FF, 10'h3FF));
    push_item(pack_req(etmr_pkg::OP_RENDER, 0, 0, 0, 0, 0, 300, 2));
    push_item(48'h7);
    push_random(80);
    drain();

    // Marker at the origin with a zero cell size, which falls back to four.
    reg_write(etmr_pkg::REG_CELL_SIZE, 0);
    reg_write(etmr_pkg::REG_PCOL, 0);
    reg_write(etmr_pkg::REG_PROW, 0);
    reg_write(etmr_pkg::REG_PARTY, 32'h0);
    push_item(pack_req(etmr_pkg::OP_RENDER, 0, 0, 0, 0, 0, 1, 1));
    push_item(pack_req(etmr_pkg::OP_RENDER, 0, 0, 0, 0, 0, 3, 3));
    push_random(80);
    drain();

    reg_write(etmr_pkg::REG_CELL_SIZE, 1);
    reg_write(etmr_pkg::REG_WALL, 32'hFFFF_FFFF);
    reg_write(etmr_pkg::REG_FLOOR, 32'h0);
    reg_write(etmr_pkg::REG_PARTY, 32'hFFFF_FFFF);
    reg_write(etmr_pkg::REG_SHOWN, 15);
    reg_write(etmr_pkg::REG_PCOL, 31);
    reg_write(etmr_pkg::REG_PROW, 31);
    push_random(90);
    drain();

    reg_write(etmr_pkg::REG_CELL_SIZE, 16);
    reg_write(etmr_pkg::REG_SHOWN, $urandom_range(0, 15));
    reg_write(etmr_pkg::REG_PCOL, 6'h20);
    reg_write(etmr_pkg::REG_PROW, 5);
    push_random(90);
    drain();

    // Cell size above sixteen is taken as written.
    reg_write(etmr_pkg::REG_CELL_SIZE, 31);
    reg_write(etmr_pkg::REG_WALL, $urandom());
    reg_write(etmr_pkg::REG_FLOOR, $urandom());
    reg_write(etmr_pkg::REG_PARTY, $urandom());
    reg_write(etmr_pkg::REG_PCOL, $urandom_range(0, 31));
    reg_write(etmr_pkg::REG_PROW, $urandom_range(0, 31));
    push_random(90);
    drain();

    reg_write(etmr_pkg::REG_CELL_SIZE, $urandom_range(2, 8));
    reg_write(etmr_pkg::REG_SHOWN, 0);
    reg_write(etmr_pkg::REG_PCOL, $urandom());
    reg_write(etmr_pkg::REG_PROW, $urandom());
    push_random(90);
    drain();

    quiet = 1'b1;
    reg_write(etmr_pkg::REG_CELL_SIZE, 4);
    reg_write(etmr_pkg::REG_PCOL, $urandom_range(0, 31));
    reg_write(etmr_pkg::REG_PROW, $urandom_range(0, 31));
    push_random(90);
    drain();

    if (n_err == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
